[hw/rtl/stq_pkg.sv]
// Shared types and constants for the multi-slot timer queue.
// Used by stq_cell, stq_ctrl and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

  // Fixed field widths of the request and result channels.
  localparam int SLOT_W     = 4;
  localparam int INTERVAL_W = 31;
  localparam int STATUS_W   = 3;
  localparam int STAMP_W    = 32;

  // At most this many slots fire on one tick.
  localparam int MAX_FIRE   = 16;
  localparam int FIRE_CNT_W = 4;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Status codes returned for start and stop.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK               = 3'd0,
    STAT_PERIODIC_RUNNING = 3'd1,
    STAT_NOT_STARTED      = 3'd2,
    STAT_ONESHOT_DONE     = 3'd3,
    STAT_ZERO_INTERVAL    = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_RESP
  } state_t;

  // Commands from the sequencer to every cell.
  typedef struct packed {
    logic load;   // latch elapsed time and clear the fired marks
    logic fire;   // fire the slot named by the fire index
    logic start;  // arm the addressed slot
    logic stop;   // disarm the addressed slot
  } cell_ctl_t;

  // Flags of the addressed slot, zero from cells that are not addressed.
  typedef struct packed {
    logic started;
    logic periodic;
    logic pending;
  } slot_flags_t;

endpackage

`default_nettype wire

[hw/rtl/multi_slot_software_timer_queue.sv]
// A start or stop request is captured and answered from S_RESP once the result
// register has room; the next request is taken after the queue returns to S_IDLE.
// A tick advances time, loads elapsed times into the cells in S_LOAD and sweeps
// the cell chain in S_SCAN, one full chain sweep per firing; the input stays
// stalled for the whole round, plus any result stall. Synchronous reset clears
// time, start counter and slot flags. Top level: stq_ctrl, stq_cell chain, stq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module multi_slot_software_timer_queue import stq_pkg::*; #(
  parameter int NUM_SLOTS  = 16,
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            operation,
  input  wire logic [SLOT_W-1:0]     slot,
  input  wire logic [INTERVAL_W-1:0] interval,
  input  wire logic                  periodic,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       kind,
  output logic [SLOT_W-1:0]          fired_slot,
  output logic [STATUS_W-1:0]        status,
  output logic                       last
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  cell_ctl_t             ctl;
  logic [SLOT_W-1:0]     req_slot;
  logic [INTERVAL_W-1:0] req_interval;
  logic                  req_periodic;
  logic [IDX_W-1:0]      fire_idx;
  logic [TIME_WIDTH-1:0] now_ms;
  logic [STAMP_W-1:0]    stamp_in;
  slot_flags_t           flags;
  slot_flags_t           cell_flags [NUM_SLOTS];

  // Candidate hand-off between neighboring cells; position 0 is the empty head.
  logic                  w_valid   [NUM_SLOTS+1];
  logic [TIME_WIDTH-1:0] w_elapsed [NUM_SLOTS+1];
  logic [STAMP_W-1:0]    w_stamp   [NUM_SLOTS+1];
  logic [IDX_W-1:0]      w_idx     [NUM_SLOTS+1];
  logic [CNT_W-1:0]      w_cnt     [NUM_SLOTS+1];

  assign w_valid[0]   = 1'b0;
  assign w_elapsed[0] = '0;
  assign w_stamp[0]   = '0;
  assign w_idx[0]     = '0;
  assign w_cnt[0]     = '0;

  stq_ctrl #(
    .NUM_SLOTS  (NUM_SLOTS),
    .TIME_WIDTH (TIME_WIDTH),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .slot         (slot),
    .interval     (interval),
    .periodic     (periodic),
    .flags        (flags),
    .tail_valid   (w_valid[NUM_SLOTS]),
    .tail_idx     (w_idx[NUM_SLOTS]),
    .tail_cnt     (w_cnt[NUM_SLOTS]),
    .ctl          (ctl),
    .req_slot     (req_slot),
    .req_interval (req_interval),
    .req_periodic (req_periodic),
    .fire_idx     (fire_idx),
    .now_ms       (now_ms),
    .stamp_in     (stamp_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .fired_slot   (fired_slot),
    .status       (status),
    .last         (last)
  );

  // Row of slot cells, each passing its best candidate to the next.
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    stq_cell #(
      .TIME_WIDTH (TIME_WIDTH),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .CELL_IDX   (i)
    ) u_cell (
      .clk             (clk),
      .rst             (rst),
      .ctl             (ctl),
      .slot            (req_slot),
      .interval        (req_interval),
      .periodic        (req_periodic),
      .fire_idx        (fire_idx),
      .now_ms          (now_ms),
      .stamp_in        (stamp_in),
      .cand_in_valid   (w_valid[i]),
      .cand_in_elapsed (w_elapsed[i]),
      .cand_in_stamp   (w_stamp[i]),
      .cand_in_idx     (w_idx[i]),
      .cand_in_cnt     (w_cnt[i]),
      .cand_valid      (w_valid[i+1]),
      .cand_elapsed    (w_elapsed[i+1]),
      .cand_stamp      (w_stamp[i+1]),
      .cand_idx        (w_idx[i+1]),
      .cand_cnt        (w_cnt[i+1]),
      .flags           (cell_flags[i])
    );
  end

  // Only the addressed cell drives nonzero flags.
  always_comb begin
    flags = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      flags.started  = flags.started  | cell_flags[i].started;
      flags.periodic = flags.periodic | cell_flags[i].periodic;
      flags.pending  = flags.pending  | cell_flags[i].pending;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/stq_cell.sv]
// One timer slot of the chain: holds the slot schedule and compares its own
// candidate against the one handed in from the previous cell. Uses stq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stq_cell import stq_pkg::*; #(
  parameter int TIME_WIDTH = 32,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5,
  parameter int CELL_IDX   = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cell_ctl_t             ctl,
  input  wire logic [SLOT_W-1:0]     slot,
  input  wire logic [INTERVAL_W-1:0] interval,
  input  wire logic                  periodic,
  input  wire logic [IDX_W-1:0]      fire_idx,
  input  wire logic [TIME_WIDTH-1:0] now_ms,
  input  wire logic [STAMP_W-1:0]    stamp_in,
  input  wire logic                  cand_in_valid,
  input  wire logic [TIME_WIDTH-1:0] cand_in_elapsed,
  input  wire logic [STAMP_W-1:0]    cand_in_stamp,
  input  wire logic [IDX_W-1:0]      cand_in_idx,
  input  wire logic [CNT_W-1:0]      cand_in_cnt,
  output logic                       cand_valid,
  output logic [TIME_WIDTH-1:0]      cand_elapsed,
  output logic [STAMP_W-1:0]         cand_stamp,
  output logic [IDX_W-1:0]           cand_idx,
  output logic [CNT_W-1:0]           cand_cnt,
  output slot_flags_t                flags
);

  logic                  pending;
  logic                  started;
  logic                  slot_periodic;
  logic                  fired;
  logic [TIME_WIDTH-1:0] deadline;
  logic [INTERVAL_W-1:0] slot_interval;
  logic [STAMP_W-1:0]    stamp;
  logic [TIME_WIDTH-1:0] elapsed;

  logic                  sel_slot;
  logic                  sel_fire;
  logic                  due;
  logic [STAMP_W-1:0]    stamp_diff;
  logic                  wins;

  // Address decode for start/stop and for firing.
  assign sel_slot = (32'(slot) == 32'(CELL_IDX));
  assign sel_fire = (fire_idx == IDX_W'(CELL_IDX));

  // Due when armed, not yet fired on this tick and the deadline is reached.
  assign due = pending && !fired && !elapsed[TIME_WIDTH-1];

  // Own slot wins over the incoming one when it is later past its deadline,
  // or equally late and started earlier. A full tie keeps the lower slot,
  // which is always the incoming one.
  assign stamp_diff = stamp - cand_in_stamp;
  assign wins = due && (!cand_in_valid || (elapsed > cand_in_elapsed) ||
                        ((elapsed == cand_in_elapsed) && stamp_diff[STAMP_W-1]));

  assign flags.started  = started & sel_slot;
  assign flags.periodic = slot_periodic & sel_slot;
  assign flags.pending  = pending & sel_slot;

  // Control flags of the slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending       <= 1'b0;
      started       <= 1'b0;
      slot_periodic <= 1'b0;
      fired         <= 1'b0;
    end else begin
      if (ctl.load) begin
        fired <= 1'b0;
      end
      if (ctl.start && sel_slot) begin
        pending       <= 1'b1;
        started       <= 1'b1;
        slot_periodic <= periodic;
      end
      if (ctl.stop && sel_slot) begin
        pending <= 1'b0;
        started <= 1'b0;
      end
      if (ctl.fire && sel_fire) begin
        fired <= 1'b1;
        if (!slot_periodic) begin
          pending <= 1'b0;
        end
      end
    end
  end

  // Schedule payload; a periodic slot re-arms from its old deadline.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      elapsed <= now_ms - deadline;
    end
    if (ctl.start && sel_slot) begin
      slot_interval <= interval;
      stamp         <= stamp_in;
      deadline      <= now_ms + TIME_WIDTH'(interval);
    end
    if (ctl.fire && sel_fire && slot_periodic) begin
      deadline <= deadline + TIME_WIDTH'(slot_interval);
    end
  end

  // Candidate stage handed to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
      cand_cnt   <= '0;
    end else begin
      cand_valid <= cand_in_valid | due;
      cand_cnt   <= cand_in_cnt + CNT_W'(due);
    end
  end

  always_ff @(posedge clk) begin
    if (wins) begin
      cand_elapsed <= elapsed;
      cand_stamp   <= stamp;
      cand_idx     <= IDX_W'(CELL_IDX);
    end else begin
      cand_elapsed <= cand_in_elapsed;
      cand_stamp   <= cand_in_stamp;
      cand_idx     <= cand_in_idx;
    end
  end

  // A periodic slot that is still armed has not been stopped.
  a_periodic_started: assert property (@(posedge clk) disable iff (rst)
    (pending && slot_periodic) |-> started)
    else $error("armed periodic slot is not marked started");

endmodule

`default_nettype wire

[hw/rtl/stq_ctrl.sv]
// Sequencer of the timer queue: request capture, time and start counters,
// firing rounds over the cell chain and the result register. Uses stq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stq_ctrl import stq_pkg::*; #(
  parameter int NUM_SLOTS  = 16,
  parameter int TIME_WIDTH = 32,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            operation,
  input  wire logic [SLOT_W-1:0]     slot,
  input  wire logic [INTERVAL_W-1:0] interval,
  input  wire logic                  periodic,
  input  wire slot_flags_t           flags,
  input  wire logic                  tail_valid,
  input  wire logic [IDX_W-1:0]      tail_idx,
  input  wire logic [CNT_W-1:0]      tail_cnt,
  output cell_ctl_t                  ctl,
  output logic [SLOT_W-1:0]          req_slot,
  output logic [INTERVAL_W-1:0]      req_interval,
  output logic                       req_periodic,
  output logic [IDX_W-1:0]           fire_idx,
  output logic [TIME_WIDTH-1:0]      now_ms,
  output logic [STAMP_W-1:0]         stamp_in,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       kind,
  output logic [SLOT_W-1:0]          fired_slot,
  output logic [STATUS_W-1:0]        status,
  output logic                       last
);

  state_t                state;
  state_t                state_next;
  op_t                   req_op;
  logic [STAMP_W-1:0]    next_stamp;
  logic [CNT_W-1:0]      scan_cnt;
  logic [CNT_W-1:0]      scan_cnt_next;
  logic [FIRE_CNT_W-1:0] fire_n;
  logic [FIRE_CNT_W-1:0] fire_n_next;

  logic                  capture;
  logic                  now_bump;
  logic                  stamp_bump;
  logic                  out_load;
  logic                  can_load;
  logic                  slot_ok;
  logic                  scan_done;
  logic                  kind_next;
  logic [SLOT_W-1:0]     fired_slot_next;
  status_t               status_next;
  logic                  last_next;

  assign can_load  = !out_valid || !out_stall;
  assign slot_ok   = (32'(req_slot) < 32'(NUM_SLOTS));
  assign scan_done = (scan_cnt == CNT_W'(NUM_SLOTS));
  assign stamp_in  = next_stamp + 32'd1;
  assign fire_idx  = tail_idx;

  // Next state, cell commands and result selection.
  always_comb begin
    state_next      = state;
    ctl             = '0;
    in_stall        = 1'b1;
    capture         = 1'b0;
    now_bump        = 1'b0;
    stamp_bump      = 1'b0;
    out_load        = 1'b0;
    kind_next       = 1'b0;
    fired_slot_next = req_slot;
    status_next     = STAT_OK;
    last_next       = 1'b1;
    scan_cnt_next   = scan_cnt;
    fire_n_next     = fire_n;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          capture = 1'b1;
          unique case (op_t'(operation))
            OP_TICK: begin
              now_bump   = 1'b1;
              state_next = S_LOAD;
            end
            OP_START, OP_STOP: begin
              state_next = S_RESP;
            end
            OP_NONE: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_LOAD: begin
        ctl.load      = 1'b1;
        scan_cnt_next = '0;
        fire_n_next   = '0;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        // The winner reaches the tail once the chain has been swept.
        if (!scan_done) begin
          scan_cnt_next = scan_cnt + CNT_W'(1);
        end else if (!tail_valid) begin
          state_next = S_IDLE;
        end else if (can_load) begin
          out_load        = 1'b1;
          kind_next       = 1'b1;
          fired_slot_next = SLOT_W'(tail_idx);
          last_next       = (tail_cnt == CNT_W'(1)) ||
                            (fire_n == FIRE_CNT_W'(MAX_FIRE - 1));
          ctl.fire        = 1'b1;
          fire_n_next     = fire_n + FIRE_CNT_W'(1);
          scan_cnt_next   = '0;
          if (last_next) begin
            state_next = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (can_load) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (req_op == OP_START) begin
            priority if (!slot_ok) begin
              status_next = STAT_NOT_STARTED;
            end else if (flags.started && flags.periodic) begin
              status_next = STAT_PERIODIC_RUNNING;
            end else if (req_interval == '0) begin
              status_next = STAT_ZERO_INTERVAL;
            end else begin
              status_next = STAT_OK;
              ctl.start   = 1'b1;
              stamp_bump  = 1'b1;
            end
          end else begin
            if (!slot_ok || !flags.started) begin
              status_next = STAT_NOT_STARTED;
            end else begin
              ctl.stop    = 1'b1;
              status_next = flags.pending ? STAT_OK : STAT_ONESHOT_DONE;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      now_ms     <= '0;
      next_stamp <= '0;
      scan_cnt   <= '0;
      fire_n     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      scan_cnt <= scan_cnt_next;
      fire_n   <= fire_n_next;
      if (now_bump) begin
        now_ms <= now_ms + TIME_WIDTH'(1);
      end
      if (stamp_bump) begin
        next_stamp <= stamp_in;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Captured request and result payload.
  always_ff @(posedge clk) begin
    if (capture) begin
      req_op       <= op_t'(operation);
      req_slot     <= slot;
      req_interval <= interval;
      req_periodic <= periodic;
    end
    if (out_load) begin
      kind       <= kind_next;
      fired_slot <= fired_slot_next;
      status     <= status_next;
      last       <= last_next;
    end
  end

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.load, ctl.fire, ctl.start, ctl.stop}))
    else $error("more than one cell command at once");

  a_fire_has_room: assert property (@(posedge clk) disable iff (rst)
    ctl.fire |-> (tail_valid && !(out_valid && out_stall)))
    else $error("firing without a winner or without room for the result");

  a_no_empty_round: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && scan_done && !tail_valid) |-> (fire_n == '0))
    else $error("empty firing round after a result not marked last");

endmodule

`default_nettype wire
